@@ rtl/core/fvsm_pkg.sv @@
`timescale 1ns / 1ps
package fvsm_pkg;
   typedef enum logic [2:0] {
      OP_WRITE = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_VOL   = 3'd3,
      OP_STOP_ALL = 3'd4,
      OP_MIX   = 3'd5
   } opcode_type;

   localparam int unsigned REQ_TDATA_W = 104;
   localparam int unsigned RSP_TDATA_W = 16;
   localparam logic [0:0] ADDR_OUTPUT_RATE = 1'b0;
   localparam logic [15:0] RATE_RESET = 16'd22050;
   localparam int signed SAT_MIN = -128;
   localparam int signed SAT_MAX = 127;
endpackage

@@ rtl/core/fvsm_divider.sv @@
`timescale 1ns / 1ps
module fvsm_divider import fvsm_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] numer,
   input  logic [15:0] denom,
   output logic        done,
   output logic [31:0] quot
);
   localparam int NW = 16 + FRAC_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [16:0]   rem_ff, rem_in;
   logic [15:0]   den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [16:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[15:0], num_ff[NW-1]};
      if (start) begin
         num_in  = {numer, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = (denom == 16'd0) ? 16'd1 : denom;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one restoring step per cycle
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
      end
   end

   assign done = busy_ff && (cnt_ff == CW'(1));
   assign quot = 32'(num_in);
endmodule

@@ rtl/core/four_voice_sample_mixer_unit.sv @@
`timescale 1ns / 1ps
// write, stop, volume, stop-all and unused opcodes complete in ST_IDLE and can be taken back to back
// start waits in ST_DIV for the one-bit-per-cycle restoring divider to give the step
// mix: 4 voice passes, each through ST_RD, ST_WAIT and ST_ACC, then the result is offered in ST_OUT
// one item at a time; req_tready is low while an item is at work or a result waits
// synchronous active-high reset clears voices and sets output_rate to 22050;
// sample memory is not cleared and reads undefined until written
module four_voice_sample_mixer_unit import fvsm_pkg::*; #(
   parameter int SAMPLE_MEM_DEPTH = 65536,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0] voice[4:3] address[20:5] data_byte[28:21] length[45:29]
   // loop_start[61:46] loop_length[78:62] freq[94:79] volume[101:95]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // left[7:0] right[15:8]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [0:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

   typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_RD, ST_WAIT, ST_ACC, ST_OUT} state_type;

   // csr
   logic [15:0] rate_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == ADDR_OUTPUT_RATE) ? {16'd0, rate_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) rate_ff <= RATE_RESET;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == ADDR_OUTPUT_RATE)
         rate_ff <= csr_pwdata[15:0];
   end

   // request fields
   logic [2:0]  f_op;
   logic [1:0]  f_voice;
   logic [15:0] f_addr, f_lps, f_freq;
   logic [7:0]  f_byte;
   logic [16:0] f_len, f_lpl;
   logic [6:0]  f_vol;
   assign f_op    = req_tdata[2:0];
   assign f_voice = req_tdata[4:3];
   assign f_addr  = req_tdata[20:5];
   assign f_byte  = req_tdata[28:21];
   assign f_len   = req_tdata[45:29];
   assign f_lps   = req_tdata[61:46];
   assign f_lpl   = req_tdata[78:62];
   assign f_freq  = req_tdata[94:79];
   assign f_vol   = req_tdata[101:95];

   // voice state
   logic [3:0]  act_ff;
   logic [15:0] base_ff [4];
   logic [16:0] len_ff  [4];
   logic [15:0] lps_ff  [4];
   logic [16:0] lpl_ff  [4];
   logic [31:0] pos_ff  [4];
   logic [31:0] step_ff [4];
   logic [6:0]  gain_ff [4];

   state_type   st_ff;
   logic [1:0]  vc_ff;       // voice pass 0..3 -> voices 0,3,1,2
   logic [1:0]  sv_ff;       // voice being started
   logic [1:0]  cur;
   logic        skip_ff;     // current voice adds nothing
   logic signed [8:0]  accl_ff, accr_ff;
   logic [7:0]  outl_ff, outr_ff;
   logic        div_start, div_done;
   logic [31:0] div_q;

   // sample memory, read only in the pass's first cycle so the sample
   // matches the position before it advances
   logic [7:0]    mem [SAMPLE_MEM_DEPTH];
   logic [7:0]    rd_ff;
   logic [AW-1:0] rd_addr;
   logic          acc_req;
   assign acc_req = req_tvalid && req_tready;
   always_ff @(posedge clock) begin
      if (acc_req && f_op == OP_WRITE) mem[f_addr[AW-1:0]] <= f_byte;
      if (st_ff == ST_RD) rd_ff <= mem[rd_addr];
   end

   always_comb begin
      case (vc_ff)
         2'd0: cur = 2'd0;
         2'd1: cur = 2'd3;
         2'd2: cur = 2'd1;
         default: cur = 2'd2;
      endcase
   end

   // step math for current voice
   logic [31:0] p_int;
   logic [32:0] loop_end, len_end;
   logic        at_loop, at_end;
   assign p_int    = pos_ff[cur] >> FRAC_BITS;
   assign loop_end = 33'(lps_ff[cur]) + 33'(lpl_ff[cur]);
   assign len_end  = 33'(len_ff[cur]);
   assign at_loop  = ({1'b0, p_int} + 33'd1) >= loop_end;
   assign at_end   = ({1'b0, p_int} + 33'd1) >= len_end;
   assign rd_addr  = AW'({16'd0, base_ff[cur]} + p_int);

   // scaled sample, truncated toward zero, added to the channel accumulator with saturation
   logic signed [15:0] prod;
   logic signed [15:0] scaled;
   logic signed [9:0]  sum;
   logic signed [8:0]  acc_sel, sat;
   assign prod    = $signed(rd_ff) * $signed({1'b0, gain_ff[cur]});
   assign scaled  = (prod < 0) ? -((-prod) >>> 6) : (prod >>> 6);
   assign acc_sel = vc_ff[1] ? accr_ff : accl_ff;
   assign sum     = 10'(acc_sel) + 10'(scaled);
   assign sat     = (sum < SAT_MIN) ? 9'(SAT_MIN) : (sum > SAT_MAX) ? 9'(SAT_MAX) : 9'(sum);

   assign div_start = acc_req && f_op == OP_START;

   fvsm_divider #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(f_freq), .denom(rate_ff), .done(div_done), .quot(div_q)
   );

   assign req_tready = (st_ff == ST_IDLE);
   assign rsp_tvalid = (st_ff == ST_OUT);
   assign rsp_tdata  = {outr_ff, outl_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         act_ff <= '0;
         vc_ff  <= '0;
         for (int i = 0; i < 4; i++) begin
            base_ff[i] <= '0; len_ff[i] <= '0; lps_ff[i] <= '0; lpl_ff[i] <= '0;
            pos_ff[i] <= '0; step_ff[i] <= '0; gain_ff[i] <= '0;
         end
      end else begin
         unique case (st_ff)
            ST_IDLE: if (acc_req) begin
               case (f_op)
                  OP_START: begin
                     sv_ff <= f_voice;
                     base_ff[f_voice] <= f_addr;
                     len_ff[f_voice]  <= f_len;
                     lps_ff[f_voice]  <= f_lps;
                     lpl_ff[f_voice]  <= f_lpl;
                     pos_ff[f_voice]  <= '0;
                     gain_ff[f_voice] <= f_vol;
                     st_ff <= ST_DIV;
                  end
                  OP_STOP: begin
                     act_ff[f_voice] <= 1'b0;
                     base_ff[f_voice] <= '0; len_ff[f_voice] <= '0;
                     lps_ff[f_voice] <= '0; lpl_ff[f_voice] <= '0;
                     pos_ff[f_voice] <= '0; step_ff[f_voice] <= '0;
                     gain_ff[f_voice] <= '0;
                  end
                  OP_VOL: gain_ff[f_voice] <= f_vol;
                  OP_STOP_ALL: begin
                     act_ff <= '0;
                     for (int i = 0; i < 4; i++) begin
                        base_ff[i] <= '0; len_ff[i] <= '0; lps_ff[i] <= '0;
                        lpl_ff[i] <= '0; pos_ff[i] <= '0; step_ff[i] <= '0;
                        gain_ff[i] <= '0;
                     end
                  end
                  OP_MIX: begin
                     vc_ff   <= '0;
                     accl_ff <= '0;
                     accr_ff <= '0;
                     st_ff   <= ST_RD;
                  end
                  default: ;
               endcase
            end
            ST_DIV: if (div_done) begin
               step_ff[sv_ff] <= div_q;
               act_ff[sv_ff]  <= 1'b1;
               st_ff <= ST_IDLE;
            end
            ST_RD: begin
               // advance position, decide loop or end; address goes to memory
               skip_ff <= !act_ff[cur] || (lpl_ff[cur] == 17'd0 && at_end);
               if (!act_ff[cur]) begin
                  // inactive voice keeps its state
               end else if (lpl_ff[cur] != 17'd0) begin
                  if (at_loop) pos_ff[cur] <= 32'({16'd0, lps_ff[cur]} << FRAC_BITS);
                  else pos_ff[cur] <= pos_ff[cur] + step_ff[cur];
               end else if (at_end) begin
                  act_ff[cur]  <= 1'b0;
                  pos_ff[cur]  <= pos_ff[cur] + step_ff[cur];
               end else begin
                  pos_ff[cur] <= pos_ff[cur] + step_ff[cur];
               end
               st_ff <= ST_WAIT;
            end
            ST_WAIT: st_ff <= ST_ACC;
            ST_ACC: begin
               if (!skip_ff) begin
                  if (vc_ff[1]) accr_ff <= sat;
                  else accl_ff <= sat;
               end
               vc_ff <= vc_ff + 2'd1;
               if (vc_ff == 2'd3) st_ff <= ST_OUT;
               else st_ff <= ST_RD;
            end
            ST_OUT: if (rsp_tready) st_ff <= ST_IDLE;
            default: st_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == ST_ACC && vc_ff == 2'd3) begin
         outl_ff <= 8'(accl_ff);
         outr_ff <= 8'(skip_ff ? accr_ff : sat);
      end else if (st_ff == ST_ACC && vc_ff == 2'd1) begin
         outl_ff <= 8'(skip_ff ? accl_ff : sat);
      end
   end
endmodule
